[design/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the clock and countdown timer unit.
// Command codes, field widths, time limits and the result record.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int PRESCALE_WIDTH = 16;
    localparam int TPS_WIDTH      = 16;
    localparam int CMP_WIDTH      = (PRESCALE_WIDTH > TPS_WIDTH) ? PRESCALE_WIDTH : TPS_WIDTH;

    localparam int CMD_WIDTH      = 3;
    localparam int DIGIT_WIDTH    = 4;
    localparam int NUM_PLACES     = 6;
    localparam int PLACE_WIDTH    = 3;
    localparam int PAIR_WIDTH     = 8;

    localparam logic [TPS_WIDTH-1:0]   TPS_RESET   = TPS_WIDTH'(1000);
    localparam logic [PLACE_WIDTH-1:0] NO_PLACE    = PLACE_WIDTH'(6);
    localparam logic [PLACE_WIDTH-1:0] LAST_PLACE  = PLACE_WIDTH'(5);

    localparam logic [5:0] MS_LAST         = 6'd59;
    localparam logic [4:0] CLK_HOUR_LAST   = 5'd23;
    localparam logic [6:0] TMR_HOUR_LAST   = 7'd99;
    localparam logic [PAIR_WIDTH-1:0] TENS = PAIR_WIDTH'(10);

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK       = 3'd0,
        CMD_DIGIT      = 3'd1,
        CMD_ADJ_CLOCK  = 3'd2,
        CMD_ADJ_TIMER  = 3'd3,
        CMD_SHOW_CLOCK = 3'd4,
        CMD_SHOW_TIMER = 3'd5
    } t_command;

    typedef struct packed {
        logic [4:0]             clock_hours;
        logic [5:0]             clock_minutes;
        logic [5:0]             clock_seconds;
        logic [6:0]             timer_hours;
        logic [5:0]             timer_minutes;
        logic [5:0]             timer_seconds;
        logic                   timer_expired;
        logic                   second_pulse;
        logic [PLACE_WIDTH-1:0] entry_position;
        logic                   value_clamped;
    } t_result;

endpackage

[design/cct_ifs.sv]
// ----------------------------------------------------------------------------
// cct channel interfaces: configuration, input item and result channels.
// Each carries valid, ready and the payload, with source and sink modports.
// ----------------------------------------------------------------------------
interface cct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cct_pkg::TPS_WIDTH-1:0]  ticks_per_second;

    modport source (output valid, output ticks_per_second, input ready);
    modport sink   (input valid, input ticks_per_second, output ready);
endinterface

interface cct_in_if;
    logic                              valid;
    logic                              ready;
    logic [cct_pkg::CMD_WIDTH-1:0]     command;
    logic [cct_pkg::DIGIT_WIDTH-1:0]   digit;
    logic                              new_press;

    modport source (output valid, output command, output digit, output new_press,
                    input ready);
    modport sink   (input valid, input command, input digit, input new_press,
                    output ready);
endinterface

interface cct_out_if;
    logic                              valid;
    logic                              ready;
    logic [4:0]                        clock_hours;
    logic [5:0]                        clock_minutes;
    logic [5:0]                        clock_seconds;
    logic [6:0]                        timer_hours;
    logic [5:0]                        timer_minutes;
    logic [5:0]                        timer_seconds;
    logic                              timer_expired;
    logic                              second_pulse;
    logic [cct_pkg::PLACE_WIDTH-1:0]   entry_position;
    logic                              value_clamped;

    modport source (output valid, output clock_hours, output clock_minutes,
                    output clock_seconds, output timer_hours, output timer_minutes,
                    output timer_seconds, output timer_expired, output second_pulse,
                    output entry_position, output value_clamped, input ready);
    modport sink   (input valid, input clock_hours, input clock_minutes,
                    input clock_seconds, input timer_hours, input timer_minutes,
                    input timer_seconds, input timer_expired, input second_pulse,
                    input entry_position, input value_clamped, output ready);
endinterface

[design/clock_and_countdown_timer_unit.sv]
// ----------------------------------------------------------------------------
// clock_and_countdown_timer_unit: time-of-day clock and countdown timer.
// Results are registered; the unit takes one item per cycle while input ready is high.
// A stalled result register takes one more transaction into a skid entry, and input
// ready then stays low until the result register drains.
// Synchronous active-low reset clears time, digits and modes; tick rate resets to 1000.
// ----------------------------------------------------------------------------
module clock_and_countdown_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cct_cfg_if.sink     i_cfg,
    cct_in_if.sink      i_item,
    cct_out_if.source   o_result
);

    logic [cct_pkg::TPS_WIDTH-1:0]      r_tps;
    logic [cct_pkg::PRESCALE_WIDTH-1:0] r_tick, n_tick;
    logic [4:0]                         r_clk_hr, n_clk_hr;
    logic [5:0]                         r_clk_min, n_clk_min;
    logic [5:0]                         r_clk_sec, n_clk_sec;
    logic [6:0]                         r_cd_hr, n_cd_hr;
    logic [5:0]                         r_cd_min, n_cd_min;
    logic [5:0]                         r_cd_sec, n_cd_sec;
    logic [cct_pkg::DIGIT_WIDTH-1:0]    r_digits [cct_pkg::NUM_PLACES];
    logic [cct_pkg::PLACE_WIDTH-1:0]    r_place, n_place;
    logic                               r_clk_adj, n_clk_adj;
    logic                               r_tmr_adj, n_tmr_adj;
    logic                               r_clk_rdy, n_clk_rdy;
    logic                               r_tmr_rdy, n_tmr_rdy;

    logic                               r_out_valid;
    logic                               r_skid_valid;
    cct_pkg::t_result                   r_out, r_skid, n_result;

    logic                               accept;
    logic                               digit_wr;
    logic                               pulse;
    logic                               clamped;
    logic [cct_pkg::PRESCALE_WIDTH-1:0] tick_inc;
    logic [cct_pkg::PAIR_WIDTH-1:0]     pair_hr, pair_min, pair_sec;

    function automatic logic [cct_pkg::PAIR_WIDTH-1:0] pair_value(
        input logic [cct_pkg::DIGIT_WIDTH-1:0] tens_digit,
        input logic [cct_pkg::DIGIT_WIDTH-1:0] ones_digit
    );
        return cct_pkg::PAIR_WIDTH'(tens_digit) * cct_pkg::TENS
               + cct_pkg::PAIR_WIDTH'(ones_digit);
    endfunction

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_skid_valid;
    assign accept       = i_item.valid && i_item.ready;

    assign pair_hr  = pair_value(r_digits[0], r_digits[1]);
    assign pair_min = pair_value(r_digits[2], r_digits[3]);
    assign pair_sec = pair_value(r_digits[4], r_digits[5]);
    assign tick_inc = r_tick + cct_pkg::PRESCALE_WIDTH'(1);

    always_comb begin
        n_tick    = r_tick;
        n_clk_hr  = r_clk_hr;
        n_clk_min = r_clk_min;
        n_clk_sec = r_clk_sec;
        n_cd_hr   = r_cd_hr;
        n_cd_min  = r_cd_min;
        n_cd_sec  = r_cd_sec;
        n_place   = r_place;
        n_clk_adj = r_clk_adj;
        n_tmr_adj = r_tmr_adj;
        n_clk_rdy = r_clk_rdy;
        n_tmr_rdy = r_tmr_rdy;
        digit_wr  = 1'b0;
        pulse     = 1'b0;
        clamped   = 1'b0;

        case (cct_pkg::t_command'(i_item.command))
            cct_pkg::CMD_TICK: begin
                if (cct_pkg::CMP_WIDTH'(tick_inc) >= cct_pkg::CMP_WIDTH'(r_tps)) begin
                    n_tick = '0;
                    pulse  = 1'b1;
                    // Clock values never leave their range, so the carry is a
                    // compare against the last legal value.
                    if (r_clk_sec >= cct_pkg::MS_LAST) begin
                        n_clk_sec = '0;
                        if (r_clk_min >= cct_pkg::MS_LAST) begin
                            n_clk_min = '0;
                            n_clk_hr  = (r_clk_hr >= cct_pkg::CLK_HOUR_LAST) ?
                                        5'd0 : r_clk_hr + 5'd1;
                        end else begin
                            n_clk_min = r_clk_min + 6'd1;
                        end
                    end else begin
                        n_clk_sec = r_clk_sec + 6'd1;
                    end
                    // The countdown holds once it reaches zero.
                    if (r_cd_hr != '0 || r_cd_min != '0 || r_cd_sec != '0) begin
                        if (r_cd_sec != '0) begin
                            n_cd_sec = r_cd_sec - 6'd1;
                        end else begin
                            n_cd_sec = cct_pkg::MS_LAST;
                            if (r_cd_min != '0) begin
                                n_cd_min = r_cd_min - 6'd1;
                            end else begin
                                n_cd_min = cct_pkg::MS_LAST;
                                n_cd_hr  = r_cd_hr - 7'd1;
                            end
                        end
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
            cct_pkg::CMD_DIGIT: begin
                if (r_tmr_adj || r_clk_adj) begin
                    if (r_tmr_adj) begin
                        n_tmr_rdy = 1'b1;
                    end else begin
                        n_clk_rdy = 1'b1;
                    end
                    if (i_item.new_press) begin
                        n_place = (r_place >= cct_pkg::LAST_PLACE) ?
                                  '0 : r_place + cct_pkg::PLACE_WIDTH'(1);
                    end
                    digit_wr = (n_place < cct_pkg::NO_PLACE);
                end
            end
            cct_pkg::CMD_ADJ_CLOCK: begin
                n_clk_adj = 1'b1;
            end
            cct_pkg::CMD_ADJ_TIMER: begin
                n_tmr_adj = 1'b1;
            end
            cct_pkg::CMD_SHOW_CLOCK: begin
                if (r_clk_rdy) begin
                    n_clk_adj = 1'b0;
                    n_clk_rdy = 1'b0;
                    n_clk_hr  = (pair_hr > 8'(cct_pkg::CLK_HOUR_LAST)) ?
                                cct_pkg::CLK_HOUR_LAST : pair_hr[4:0];
                    n_clk_min = (pair_min > 8'(cct_pkg::MS_LAST)) ?
                                cct_pkg::MS_LAST : pair_min[5:0];
                    n_clk_sec = (pair_sec > 8'(cct_pkg::MS_LAST)) ?
                                cct_pkg::MS_LAST : pair_sec[5:0];
                    clamped   = (pair_hr > 8'(cct_pkg::CLK_HOUR_LAST)) ||
                                (pair_min > 8'(cct_pkg::MS_LAST)) ||
                                (pair_sec > 8'(cct_pkg::MS_LAST));
                end
            end
            cct_pkg::CMD_SHOW_TIMER: begin
                if (r_tmr_rdy) begin
                    n_tmr_adj = 1'b0;
                    n_tmr_rdy = 1'b0;
                    n_cd_hr   = (pair_hr > 8'(cct_pkg::TMR_HOUR_LAST)) ?
                                cct_pkg::TMR_HOUR_LAST : pair_hr[6:0];
                    n_cd_min  = (pair_min > 8'(cct_pkg::MS_LAST)) ?
                                cct_pkg::MS_LAST : pair_min[5:0];
                    n_cd_sec  = (pair_sec > 8'(cct_pkg::MS_LAST)) ?
                                cct_pkg::MS_LAST : pair_sec[5:0];
                    clamped   = (pair_hr > 8'(cct_pkg::TMR_HOUR_LAST)) ||
                                (pair_min > 8'(cct_pkg::MS_LAST)) ||
                                (pair_sec > 8'(cct_pkg::MS_LAST));
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_result.clock_hours    = n_clk_hr;
        n_result.clock_minutes  = n_clk_min;
        n_result.clock_seconds  = n_clk_sec;
        n_result.timer_hours    = n_cd_hr;
        n_result.timer_minutes  = n_cd_min;
        n_result.timer_seconds  = n_cd_sec;
        n_result.timer_expired  = (n_cd_hr == '0) && (n_cd_min == '0) && (n_cd_sec == '0);
        n_result.second_pulse   = pulse;
        n_result.entry_position = n_place;
        n_result.value_clamped  = clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps     <= cct_pkg::TPS_RESET;
            r_tick    <= '0;
            r_clk_hr  <= '0;
            r_clk_min <= '0;
            r_clk_sec <= '0;
            r_cd_hr   <= '0;
            r_cd_min  <= '0;
            r_cd_sec  <= '0;
            r_place   <= cct_pkg::NO_PLACE;
            r_clk_adj <= 1'b0;
            r_tmr_adj <= 1'b0;
            r_clk_rdy <= 1'b0;
            r_tmr_rdy <= 1'b0;
            for (int i = 0; i < cct_pkg::NUM_PLACES; i++) begin
                r_digits[i] <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_tps <= i_cfg.ticks_per_second;
            end
            if (accept) begin
                r_tick    <= n_tick;
                r_clk_hr  <= n_clk_hr;
                r_clk_min <= n_clk_min;
                r_clk_sec <= n_clk_sec;
                r_cd_hr   <= n_cd_hr;
                r_cd_min  <= n_cd_min;
                r_cd_sec  <= n_cd_sec;
                r_place   <= n_place;
                r_clk_adj <= n_clk_adj;
                r_tmr_adj <= n_tmr_adj;
                r_clk_rdy <= n_clk_rdy;
                r_tmr_rdy <= n_tmr_rdy;
                if (digit_wr) begin
                    r_digits[n_place] <= i_item.digit;
                end
            end
        end
    end

    // Result register with one skid entry: a new transaction lands in the
    // skid entry only when the result register is full and stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || o_result.ready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_result.ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.clock_hours    = r_out.clock_hours;
    assign o_result.clock_minutes  = r_out.clock_minutes;
    assign o_result.clock_seconds  = r_out.clock_seconds;
    assign o_result.timer_hours    = r_out.timer_hours;
    assign o_result.timer_minutes  = r_out.timer_minutes;
    assign o_result.timer_seconds  = r_out.timer_seconds;
    assign o_result.timer_expired  = r_out.timer_expired;
    assign o_result.second_pulse   = r_out.second_pulse;
    assign o_result.entry_position = r_out.entry_position;
    assign o_result.value_clamped  = r_out.value_clamped;

endmodule
